// ===== hdl/rnpi_pkg.sv =====
// Shared types, constants and helpers for the nearest palette index core.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package rnpi_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int CHANNEL_BITS    = 5;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int DIST_W          = 18;
  localparam int SQ_W            = 16;
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // One palette entry presented to the distance unit.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [IDX_W-1:0] idx;
    color_t           color;
  } feed_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } best_t;

  // Widen a channel to 8 bits by bit replication.
  function automatic logic [7:0] widen_channel(input logic [CHANNEL_BITS-1:0] c);
    logic [7:0] v;
    v = 8'(c);
    return 8'((v << (8 - CHANNEL_BITS)) | (v >> (2 * CHANNEL_BITS - 8)));
  endfunction

  function automatic logic [SQ_W-1:0] square_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rnpi_cell.sv =====
// One cell of the palette ring: holds a single 24-bit entry.
// Depends on rnpi_pkg for the colour type.
`default_nettype none

module rnpi_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire logic            wr_i,
  input  wire rnpi_pkg::color_t wr_data_i,
  input  wire rnpi_pkg::color_t nb_data_i,
  output rnpi_pkg::color_t     data_o
);
  import rnpi_pkg::*;

  color_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = nb_data_i;
    end else if (wr_i) begin
      data_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hdl/rnpi_dist.sv =====
// Two-stage distance unit: squares channel differences, then keeps the running best.
// Depends on rnpi_pkg for the feed and best types and square_diff.
`default_nettype none

module rnpi_dist (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rnpi_pkg::color_t query_i,
  input  wire rnpi_pkg::feed_t  feed_i,
  output rnpi_pkg::best_t       best_o
);
  import rnpi_pkg::*;

  logic             s1_valid_q;
  logic             s1_first_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [SQ_W-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] sum;
  best_t            best_q, best_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= feed_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= feed_i.first;
    s1_idx_q   <= feed_i.idx;
    sq_r_q     <= square_diff(query_i.red,   feed_i.color.red);
    sq_g_q     <= square_diff(query_i.green, feed_i.color.green);
    sq_b_q     <= square_diff(query_i.blue,  feed_i.color.blue);
  end

  assign sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  // Only a strictly smaller distance replaces the best, so ties keep the lower index.
  always_comb begin
    best_d = best_q;
    if (s1_valid_q && (s1_first_q || (sum < best_q.distance))) begin
      best_d.idx      = s1_idx_q;
      best_d.distance = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

// ===== hdl/rgb555_nearest_palette_index_core.sv =====
// Nearest palette index core. A write request (func 0) stores one palette entry. A
// query request (func 1) rotates the 256-cell palette ring once past one distance
// unit, one entry per cycle, then holds in ST_PUSH until the result register is free;
// no new request is taken before the result is pushed. Entries must all be written before the first query.
// Depends on rnpi_pkg, rnpi_cell and rnpi_dist.
`default_nettype none

module rgb555_nearest_palette_index_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [7:0]                        entry_index_i,
  input  wire logic [7:0]                        pal_red_i,
  input  wire logic [7:0]                        pal_green_i,
  input  wire logic [7:0]                        pal_blue_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_red_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_green_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_blue_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [7:0]                             color_index_o,
  output logic [rnpi_pkg::DIST_W-1:0]            best_distance_o
);
  import rnpi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             last;
  logic             accept, wr_en, shift;
  logic             push;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       color_index_q;
  logic [DIST_W-1:0] best_distance_q;
  color_t           query_q;
  color_t           wr_data;
  color_t           cell_data [PALETTE_ENTRIES];
  feed_t            feed;
  best_t            best;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && !func_i;
  assign shift      = (state_q == ST_SCAN);
  assign last       = (cnt_q == IDX_W'(PALETTE_ENTRIES - 1));
  assign wr_data    = '{red: pal_red_i, green: pal_green_i, blue: pal_blue_i};

  // Palette ring: cell k takes from cell k+1, cell 0 feeds the distance unit.
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    localparam int Nxt = (k + 1) % PALETTE_ENTRIES;
    rnpi_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .wr_i      (wr_en && (entry_index_i == 8'(k))),
      .wr_data_i (wr_data),
      .nb_data_i (cell_data[Nxt]),
      .data_o    (cell_data[k])
    );
  end

  assign feed = '{valid: shift, first: (cnt_q == '0), idx: cnt_q, color: cell_data[0]};

  rnpi_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_q),
    .feed_i  (feed),
    .best_o  (best)
  );

  always_ff @(posedge clk_i) begin
    if (accept && func_i) begin
      query_q <= '{red:   widen_channel(query_red_i),
                   green: widen_channel(query_green_i),
                   blue:  widen_channel(query_blue_i)};
    end
  end

  assign push = (state_q == ST_PUSH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WAIT: state_d = ST_PUSH;
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      color_index_q   <= 8'(best.idx);
      best_distance_q <= best.distance;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_index_o   = color_index_q;
  assign best_distance_o = best_distance_q;

  // The ring must be back at its home position once a scan ends.
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last) |=> (cnt_q == '0 && state_q == ST_WAIT))
    else $error("scan counter did not wrap at end of scan");

  a_query_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i) |=> (state_q == ST_SCAN))
    else $error("query request did not start a scan");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_distance_o <= MAX_DIST))
    else $error("distance out of range");

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_PUSH))
    else $error("result raised outside push state");

endmodule

`default_nettype wire

// ===== tb/rnpi_tb_pkg.sv =====
// Request codes shared by the nearest palette index testbench files.
// No dependencies; imported by the checker and by the top.
`timescale 1ns / 100ps

package rnpi_tb_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } palette_op_e;

endpackage

// ===== tb/palette_search_checker.sv =====
// Checker for the nearest palette index core: watches both channels, keeps its own
// palette copy, predicts each query result and compares it. Depends on rnpi_pkg and
// rnpi_tb_pkg.
`timescale 1ns / 100ps

module palette_search_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire logic                              func_i,
  input  wire logic [7:0]                        entry_index_i,
  input  wire logic [7:0]                        pal_red_i,
  input  wire logic [7:0]                        pal_green_i,
  input  wire logic [7:0]                        pal_blue_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_red_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_green_i,
  input  wire logic [rnpi_pkg::CHANNEL_BITS-1:0] query_blue_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic [7:0]                        color_index_i,
  input  wire logic [rnpi_pkg::DIST_W-1:0]       best_distance_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  import rnpi_pkg::*;
  import rnpi_tb_pkg::*;

  typedef struct packed {
    logic [7:0]        idx;
    logic [DIST_W-1:0] distance;
  } match_t;

  color_t shade_copy [PALETTE_ENTRIES];
  match_t pending_matches [$];
  int     failures = 0;

  assign fail_count_o = failures;

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      shade_copy[i] = '0;
    end
  end

  // Replicate the top bits of the channel into the freed low bits.
  function automatic int expand_channel(input logic [CHANNEL_BITS-1:0] c);
    int v;
    v = int'(c);
    return ((v << (8 - CHANNEL_BITS)) | (v >> (2 * CHANNEL_BITS - 8))) & 255;
  endfunction

  // Scan every entry; only a strictly smaller distance replaces the best, so the
  // lowest index wins a tie.
  function automatic match_t nearest_entry(input logic [CHANNEL_BITS-1:0] qr,
                                           input logic [CHANNEL_BITS-1:0] qg,
                                           input logic [CHANNEL_BITS-1:0] qb);
    match_t best;
    int     wr, wg, wb, dr, dg, db, d, best_d;
    wr     = expand_channel(qr);
    wg     = expand_channel(qg);
    wb     = expand_channel(qb);
    best_d = 32'h7fff_ffff;
    best   = '0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr = wr - int'(shade_copy[i].red);
      dg = wg - int'(shade_copy[i].green);
      db = wb - int'(shade_copy[i].blue);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d   = d;
        best.idx = 8'(i);
      end
    end
    best.distance = DIST_W'(best_d);
    return best;
  endfunction

  always @(posedge clk_i) begin : watch
    match_t want;
    if (rst_ni) begin
      // Results first: one accepted on this edge belongs to an earlier request.
      if (out_valid_i && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result index %0d distance %0d with no query outstanding",
                     $time, color_index_i, best_distance_i);
          end
        end else begin
          want = pending_matches.pop_front();
          if (color_index_i !== want.idx) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: color_index expected %0d, got %0d",
                       $time, want.idx, color_index_i);
            end
          end
          if (best_distance_i !== want.distance) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: best_distance expected %0d, got %0d",
                       $time, want.distance, best_distance_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == OP_WRITE) begin
          if (int'(entry_index_i) < PALETTE_ENTRIES) begin
            shade_copy[entry_index_i] = {pal_red_i, pal_green_i, pal_blue_i};
          end
        end else begin
          pending_matches.push_back(nearest_entry(query_red_i, query_green_i, query_blue_i));
        end
      end
      pending_o <= pending_matches.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the nearest palette index testbench: clock, reset, request and result
// traffic with random idling, and the verdict. Depends on rnpi_pkg, rnpi_tb_pkg,
// palette_search_checker and the core.
`timescale 1ns / 100ps

module tb;
  import rnpi_pkg::*;
  import rnpi_tb_pkg::*;

  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES     = 300;
  localparam int RANDOM_PER_PHASE = 60;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    func_i;
  logic [7:0]              entry_index_i;
  logic [7:0]              pal_red_i;
  logic [7:0]              pal_green_i;
  logic [7:0]              pal_blue_i;
  logic [CHANNEL_BITS-1:0] query_red_i;
  logic [CHANNEL_BITS-1:0] query_green_i;
  logic [CHANNEL_BITS-1:0] query_blue_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [7:0]              color_index_o;
  logic [DIST_W-1:0]       best_distance_o;

  int          fail_count;
  int          pending_count;
  int          send_idle_pct  = 36;
  int          recv_idle_pct  = 82;
  bit          long_hold_go   = 1'b0;
  bit          long_hold_done = 1'b0;
  logic [14:0] last_exact;

  rgb555_nearest_palette_index_core dut (.*);

  palette_search_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .pal_red_i       (pal_red_i),
    .pal_green_i     (pal_green_i),
    .pal_blue_i      (pal_blue_i),
    .query_red_i     (query_red_i),
    .query_green_i   (query_green_i),
    .query_blue_i    (query_blue_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .color_index_i   (color_index_o),
    .best_distance_i (best_distance_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Palette colour that a 5-bit query matches exactly.
  function automatic color_t widened(input logic [14:0] rgb);
    return {rgb[14:10], rgb[14:12], rgb[9:5], rgb[9:7], rgb[4:0], rgb[4:2]};
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  task automatic put_request(input palette_op_e op, input logic [7:0] idx,
                             input color_t shade, input logic [14:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    entry_index_i <= idx;
    pal_red_i     <= shade.red;
    pal_green_i   <= shade.green;
    pal_blue_i    <= shade.blue;
    query_red_i   <= rgb[14:10];
    query_green_i <= rgb[9:5];
    query_blue_i  <= rgb[4:0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_entry(input logic [7:0] idx, input color_t shade);
    put_request(OP_WRITE, idx, shade, 15'($urandom));
  endtask

  task automatic query_color(input logic [14:0] rgb);
    put_request(OP_QUERY, 8'($urandom), color_t'(24'($urandom)), rgb);
  endtask

  // Random palette writes and lookups, with exact-match colours and duplicated entries for ties.
  task automatic run_random(input int count);
    logic [14:0] rgb;
    color_t      shade;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(99) < 40) begin
          rgb        = 15'($urandom);
          last_exact = rgb;
          shade      = widened(rgb);
        end else begin
          shade = color_t'(24'($urandom));
        end
        write_entry(8'($urandom), shade);
        if ($urandom_range(9) == 0) begin
          write_entry(8'($urandom), shade);
        end
      end else if (pick < 60) begin
        query_color(last_exact);
      end else begin
        query_color(15'($urandom));
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        repeat (LONG_HOLD_CYCLES) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    func_i        = OP_WRITE;
    entry_index_i = '0;
    pal_red_i     = '0;
    pal_green_i   = '0;
    pal_blue_i    = '0;
    query_red_i   = '0;
    query_green_i = '0;
    query_blue_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-white palette: a black query lands at the largest distance.
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      write_entry(8'(i), '1);
    end
    query_color('0);
    query_color('1);
    // Black at the top index, then a second black lower down to force a tie.
    write_entry(8'd255, '0);
    query_color('0);
    write_entry(8'd128, '0);
    query_color('0);
    write_entry(8'd7, widened({5'd10, 5'd20, 5'd30}));
    query_color({5'd10, 5'd20, 5'd30});
    query_color({5'd31, 5'd0, 5'd31});
    query_color({5'd16, 5'd15, 5'd1});
    last_exact = 15'($urandom);

    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 82;
    recv_idle_pct = 36;
    run_random(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_go  = 1'b1;
    run_random(RANDOM_PER_PHASE);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
